// File: hdl/lpr_pkg.sv
package lpr_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int PTR_W     = $clog2(BUF_BYTES);
    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int FREE_W    = 12;
    localparam int WIDE_W    = LEN_W + 1;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int HDR_BYTES = 2;

    localparam logic [REQ_W-1:0] REQ_BEGIN_PUT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUT_DATA  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET_HDR   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ_DATA = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_SEQ = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [LEN_W-1:0]  len;
        logic [WIDE_W-1:0] need;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  got_length;
        logic [BYTE_W-1:0] read_byte;
        logic              last_byte;
        logic [FREE_W-1:0] free_space;
    } t_res;

endpackage

// File: hdl/lpr_front.sv
module lpr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [lpr_pkg::REQ_W-1:0]     i_req_type,
    input  logic [lpr_pkg::LEN_W-1:0]     i_pkt_length,
    input  logic [lpr_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_cmd_valid,
    output lpr_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);

    lpr_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          push_ok;
    logic          pop_ok;
    lpr_pkg::t_cmd in_cmd;

    // The space check of a begin-put needs length plus the header size, so it is
    // worked out here, ahead of the sequencer.
    always_comb begin
        in_cmd.req  = i_req_type;
        in_cmd.len  = i_pkt_length;
        in_cmd.need = lpr_pkg::WIDE_W'(i_pkt_length) + lpr_pkg::WIDE_W'(lpr_pkg::HDR_BYTES);
        in_cmd.data = i_data_byte;
    end

    assign full        = (r_cnt == 2'd2);
    assign push_ok     = push && !full;
    assign pop_ok      = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= in_cmd;
        end
    end

endmodule

// File: hdl/lpr_back.sv
module lpr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lpr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_valid,
    output lpr_pkg::t_res o_res
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PUT_HI   = 3'd1;
    localparam logic [2:0] ST_GET_LO   = 3'd2;
    localparam logic [2:0] ST_GET_HI   = 3'd3;
    localparam logic [2:0] ST_READ_OUT = 3'd4;

    logic [lpr_pkg::BYTE_W-1:0] r_mem [lpr_pkg::BUF_BYTES];
    logic [lpr_pkg::BYTE_W-1:0] r_rdata;

    logic [2:0]                 r_state,   n_state;
    logic [lpr_pkg::PTR_W-1:0]  r_wp,      n_wp;
    logic [lpr_pkg::PTR_W-1:0]  r_rp,      n_rp;
    logic [lpr_pkg::LEN_W-1:0]  r_put_rem, n_put_rem;
    logic [lpr_pkg::LEN_W-1:0]  r_get_rem, n_get_rem;
    logic [lpr_pkg::BYTE_W-1:0] r_hold,    n_hold;

    logic                       mem_we;
    logic                       mem_re;
    logic [lpr_pkg::PTR_W-1:0]  mem_addr;
    logic [lpr_pkg::BYTE_W-1:0] mem_wdata;
    logic [lpr_pkg::WIDE_W-1:0] free_cur;
    logic [lpr_pkg::WIDE_W-1:0] free_new;

    function automatic logic [lpr_pkg::PTR_W-1:0] ring_next(
        input logic [lpr_pkg::PTR_W-1:0] p
    );
        if (p == lpr_pkg::PTR_W'(lpr_pkg::BUF_BYTES - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [lpr_pkg::WIDE_W-1:0] free_of(
        input logic [lpr_pkg::PTR_W-1:0] wp,
        input logic [lpr_pkg::PTR_W-1:0] rp
    );
        logic [lpr_pkg::WIDE_W-1:0] used;
        if (wp >= rp) begin
            used = lpr_pkg::WIDE_W'(wp) - lpr_pkg::WIDE_W'(rp);
        end else begin
            used = lpr_pkg::WIDE_W'(wp) + lpr_pkg::WIDE_W'(lpr_pkg::BUF_BYTES)
                 - lpr_pkg::WIDE_W'(rp);
        end
        return lpr_pkg::WIDE_W'(lpr_pkg::BUF_BYTES - 1) - used;
    endfunction

    assign free_cur = free_of(r_wp, r_rp);
    assign free_new = free_of(n_wp, n_rp);

    always_comb begin
        n_state          = r_state;
        n_wp             = r_wp;
        n_rp             = r_rp;
        n_put_rem        = r_put_rem;
        n_get_rem        = r_get_rem;
        n_hold           = r_hold;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = r_wp;
        mem_wdata        = i_cmd.data;
        o_cmd_pop        = 1'b0;
        o_res_valid      = 1'b0;
        o_res.status     = lpr_pkg::STAT_OK;
        o_res.got_length = '0;
        o_res.read_byte  = '0;
        o_res.last_byte  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                // A transaction starts only when the result queue has room; nothing
                // else fills that queue, so the room is still there when it ends.
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.req)
                        lpr_pkg::REQ_BEGIN_PUT: begin
                            if (r_put_rem != '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lpr_pkg::STAT_BAD_SEQ;
                            end else if (free_cur < i_cmd.need) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lpr_pkg::STAT_NO_ROOM;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = i_cmd.len[lpr_pkg::BYTE_W-1:0];
                                n_wp      = ring_next(r_wp);
                                n_hold    = i_cmd.len[lpr_pkg::LEN_W-1:lpr_pkg::BYTE_W];
                                n_put_rem = i_cmd.len;
                                n_state   = ST_PUT_HI;
                            end
                        end
                        lpr_pkg::REQ_PUT_DATA: begin
                            o_res_valid = 1'b1;
                            if (r_put_rem == '0) begin
                                o_res.status = lpr_pkg::STAT_BAD_SEQ;
                            end else begin
                                mem_we    = 1'b1;
                                n_wp      = ring_next(r_wp);
                                n_put_rem = r_put_rem - 1'b1;
                            end
                        end
                        lpr_pkg::REQ_GET_HDR: begin
                            if ((r_put_rem != '0) || (r_get_rem != '0)) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lpr_pkg::STAT_BAD_SEQ;
                            end else if (r_wp == r_rp) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lpr_pkg::STAT_EMPTY;
                            end else begin
                                mem_re   = 1'b1;
                                mem_addr = r_rp;
                                n_rp     = ring_next(r_rp);
                                n_state  = ST_GET_LO;
                            end
                        end
                        default: begin
                            if (r_get_rem == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = lpr_pkg::STAT_BAD_SEQ;
                            end else begin
                                mem_re    = 1'b1;
                                mem_addr  = r_rp;
                                n_rp      = ring_next(r_rp);
                                n_get_rem = r_get_rem - 1'b1;
                                n_state   = ST_READ_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_PUT_HI: begin
                mem_we      = 1'b1;
                mem_wdata   = r_hold;
                n_wp        = ring_next(r_wp);
                o_res_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_GET_LO: begin
                n_hold   = r_rdata;
                mem_re   = 1'b1;
                mem_addr = r_rp;
                n_rp     = ring_next(r_rp);
                n_state  = ST_GET_HI;
            end
            ST_GET_HI: begin
                o_res.got_length = {r_rdata, r_hold};
                n_get_rem        = {r_rdata, r_hold};
                o_res_valid      = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_READ_OUT: begin
                o_res.read_byte = r_rdata;
                o_res.last_byte = (r_get_rem == '0);
                o_res_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_res.free_space = free_new[lpr_pkg::FREE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_put_rem <= '0;
            r_get_rem <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_put_rem <= n_put_rem;
            r_get_rem <= n_get_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

endmodule

// File: hdl/lpr_resq.sv
module lpr_resq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_res_valid,
    input  lpr_pkg::t_res                 i_res,
    output logic                          o_res_full,
    output logic                          empty,
    input  logic                          pop,
    output logic [lpr_pkg::STAT_W-1:0]    o_status,
    output logic [lpr_pkg::LEN_W-1:0]     o_got_length,
    output logic [lpr_pkg::BYTE_W-1:0]    o_read_byte,
    output logic                          o_last_byte,
    output logic [lpr_pkg::FREE_W-1:0]    o_free_space
);

    lpr_pkg::t_res r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          push_ok;
    logic          pop_ok;
    lpr_pkg::t_res head;

    assign o_res_full   = (r_cnt == 2'd2);
    assign empty        = (r_cnt == 2'd0);
    assign push_ok      = i_res_valid && !o_res_full;
    assign pop_ok       = pop && !empty;
    assign head         = r_q[r_rd];
    assign o_status     = head.status;
    assign o_got_length = head.got_length;
    assign o_read_byte  = head.read_byte;
    assign o_last_byte  = head.last_byte;
    assign o_free_space = head.free_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

// File: hdl/length_prefixed_packet_ring.sv
// Channel   Direction  Handshake             Payload
// request   in         push / full           i_req_type, i_pkt_length, i_data_byte
// result    out        empty / pop           o_status, o_got_length, o_read_byte,
//                                            o_last_byte, o_free_space
//
// The sequencer handles a data byte put or an error in its idle state, a begin-put
// in the idle and PUT_HI states, a byte read in the idle and READ_OUT states, and a
// header get in the idle, GET_LO and GET_HI states; the single port of the byte
// store sets these steps. Two-entry request and result queues sit on either side.
// Reset clears the pointers, the counters and both queues; the store is not cleared.
// The sequencer waits while the result queue is full.
module length_prefixed_packet_ring (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [lpr_pkg::REQ_W-1:0]     i_req_type,
    input  logic [lpr_pkg::LEN_W-1:0]     i_pkt_length,
    input  logic [lpr_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [lpr_pkg::STAT_W-1:0]    o_status,
    output logic [lpr_pkg::LEN_W-1:0]     o_got_length,
    output logic [lpr_pkg::BYTE_W-1:0]    o_read_byte,
    output logic                          o_last_byte,
    output logic [lpr_pkg::FREE_W-1:0]    o_free_space
);

    logic          cmd_valid;
    lpr_pkg::t_cmd cmd;
    logic          cmd_pop;
    logic          res_full;
    logic          res_valid;
    lpr_pkg::t_res res;

    lpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_pkt_length (i_pkt_length),
        .i_data_byte  (i_data_byte),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    lpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpr_resq u_resq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_res_full   (res_full),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_got_length (o_got_length),
        .o_read_byte  (o_read_byte),
        .o_last_byte  (o_last_byte),
        .o_free_space (o_free_space)
    );

endmodule

// File: hdl/lpr_checker.sv
module lpr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [lpr_pkg::STAT_W-1:0]    o_status,
    input logic [lpr_pkg::LEN_W-1:0]     o_got_length,
    input logic [lpr_pkg::BYTE_W-1:0]    o_read_byte,
    input logic                          o_last_byte,
    input logic [lpr_pkg::FREE_W-1:0]    o_free_space
);

    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // A rejected transaction carries no length, no byte and no last flag.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != lpr_pkg::STAT_OK))
        |-> ((o_got_length == '0) && (o_read_byte == '0) && !o_last_byte))
        else $error("error result carries payload");

    // A get reports a length and a read reports a byte, never both at once; this is checked on last-byte results.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_byte) |-> (o_got_length == '0))
        else $error("byte result also carries a length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_free_space)))
        else $error("waiting result changed");

endmodule

bind length_prefixed_packet_ring lpr_checker u_lpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_status     (o_status),
    .o_got_length (o_got_length),
    .o_read_byte  (o_read_byte),
    .o_last_byte  (o_last_byte),
    .o_free_space (o_free_space)
);

// File: bench/tb.sv
module tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1230;

    typedef struct packed {
        logic [lpr_pkg::REQ_W-1:0]  req;
        logic [lpr_pkg::LEN_W-1:0]  len;
        logic [lpr_pkg::BYTE_W-1:0] data;
        logic                       hold;
    } t_ring_req;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         pop = 1'b0;
    logic [lpr_pkg::REQ_W-1:0]    i_req_type = lpr_pkg::REQ_BEGIN_PUT;
    logic [lpr_pkg::LEN_W-1:0]    i_pkt_length = '0;
    logic [lpr_pkg::BYTE_W-1:0]   i_data_byte = '0;
    logic                         full;
    logic                         empty;
    logic [lpr_pkg::STAT_W-1:0]   o_status;
    logic [lpr_pkg::LEN_W-1:0]    o_got_length;
    logic [lpr_pkg::BYTE_W-1:0]   o_read_byte;
    logic                         o_last_byte;
    logic [lpr_pkg::FREE_W-1:0]   o_free_space;

    // Mirror of the ring used to work out what each request returns.
    logic [lpr_pkg::BYTE_W-1:0]   ring_bytes [lpr_pkg::BUF_BYTES];
    logic [lpr_pkg::PTR_W-1:0]    ring_wr = '0;
    logic [lpr_pkg::PTR_W-1:0]    ring_rd = '0;
    logic [lpr_pkg::LEN_W-1:0]    put_owed = '0;
    logic [lpr_pkg::LEN_W-1:0]    get_left = '0;

    // Planning state for the stimulus, kept as plain counts.
    int                  plan_room = lpr_pkg::BUF_BYTES - 1;
    int                  plan_owed = 0;
    int                  plan_left = 0;
    int                  plan_lens[$];
    int                  planned = 0;
    bit                  hold_next = 1'b0;

    t_ring_req           pending[$];
    lpr_pkg::t_res       due_results[$];
    t_ring_req           on_wire;
    lpr_pkg::t_res       want;
    bit                  loaded;
    int                  send_wait = 0;
    int                  send_calm = 0;
    int                  take_wait = 0;
    int                  take_calm = 0;
    int                  taken_cnt = 0;
    int                  err_cnt = 0;
    int                  quiet_cycles = 0;

    length_prefixed_packet_ring u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_pkt_length (i_pkt_length),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_got_length (o_got_length),
        .o_read_byte  (o_read_byte),
        .o_last_byte  (o_last_byte),
        .o_free_space (o_free_space)
    );

    always #5 i_clk = ~i_clk;

    function automatic int ring_room();
        logic [lpr_pkg::PTR_W-1:0] used;
        used = ring_wr - ring_rd;
        return lpr_pkg::BUF_BYTES - 1 - int'(used);
    endfunction

    function automatic lpr_pkg::t_res predict_ring(t_ring_req it);
        lpr_pkg::t_res r;
        logic [lpr_pkg::BYTE_W-1:0] lo;
        logic [lpr_pkg::BYTE_W-1:0] hi;
        r = '0;
        r.status = lpr_pkg::STAT_OK;
        case (it.req)
            lpr_pkg::REQ_BEGIN_PUT: begin
                if (put_owed != 0) begin
                    r.status = lpr_pkg::STAT_BAD_SEQ;
                end else if (ring_room() < int'(it.len) + lpr_pkg::HDR_BYTES) begin
                    r.status = lpr_pkg::STAT_NO_ROOM;
                end else begin
                    ring_bytes[ring_wr] = it.len[7:0];
                    ring_wr = ring_wr + 1'b1;
                    ring_bytes[ring_wr] = it.len[15:8];
                    ring_wr = ring_wr + 1'b1;
                    put_owed = it.len;
                end
            end
            lpr_pkg::REQ_PUT_DATA: begin
                if (put_owed == 0) begin
                    r.status = lpr_pkg::STAT_BAD_SEQ;
                end else begin
                    ring_bytes[ring_wr] = it.data;
                    ring_wr = ring_wr + 1'b1;
                    put_owed = put_owed - 1'b1;
                end
            end
            lpr_pkg::REQ_GET_HDR: begin
                if (put_owed != 0 || get_left != 0) begin
                    r.status = lpr_pkg::STAT_BAD_SEQ;
                end else if (ring_wr == ring_rd) begin
                    r.status = lpr_pkg::STAT_EMPTY;
                end else begin
                    lo = ring_bytes[ring_rd];
                    ring_rd = ring_rd + 1'b1;
                    hi = ring_bytes[ring_rd];
                    ring_rd = ring_rd + 1'b1;
                    r.got_length = {hi, lo};
                    get_left = {hi, lo};
                end
            end
            lpr_pkg::REQ_READ_DATA: begin
                if (get_left == 0) begin
                    r.status = lpr_pkg::STAT_BAD_SEQ;
                end else begin
                    r.read_byte = ring_bytes[ring_rd];
                    ring_rd = ring_rd + 1'b1;
                    get_left = get_left - 1'b1;
                    r.last_byte = (get_left == 0);
                end
            end
            default: r.status = lpr_pkg::STAT_BAD_SEQ;
        endcase
        r.free_space = lpr_pkg::FREE_W'(ring_room());
        return r;
    endfunction

    function automatic int draw_wait(inout int calm_left);
        int w;
        if (calm_left > 0) begin
            calm_left--;
            w = 0;
        end else begin
            w = $urandom_range(0, 13);
            // Now and then a run of transactions goes through back to back.
            if ($urandom_range(0, 29) == 0) begin
                calm_left = $urandom_range(8, 40);
            end
        end
        return w;
    endfunction

    function automatic void queue_req(logic [lpr_pkg::REQ_W-1:0] req, int len, int data);
        t_ring_req it;
        it.req = req;
        it.len = lpr_pkg::LEN_W'(len);
        it.data = lpr_pkg::BYTE_W'(data);
        it.hold = hold_next;
        hold_next = 1'b0;
        case (req)
            lpr_pkg::REQ_BEGIN_PUT: begin
                if (plan_owed == 0 && plan_room >= len + lpr_pkg::HDR_BYTES) begin
                    plan_room -= len + lpr_pkg::HDR_BYTES;
                    plan_owed = len;
                    plan_lens.push_back(len);
                end
            end
            lpr_pkg::REQ_PUT_DATA: begin
                if (plan_owed > 0) begin
                    plan_owed--;
                    plan_room--;
                end
            end
            lpr_pkg::REQ_GET_HDR: begin
                if (plan_owed == 0 && plan_left == 0 &&
                    plan_room != lpr_pkg::BUF_BYTES - 1) begin
                    plan_left = plan_lens.pop_front();
                    plan_room += lpr_pkg::HDR_BYTES;
                end
            end
            default: begin
                if (plan_left > 0) begin
                    plan_left--;
                    plan_room++;
                end
            end
        endcase
        pending.push_back(it);
        planned++;
    endfunction

    function automatic void queue_data(int n);
        repeat (n) queue_req(lpr_pkg::REQ_PUT_DATA, $urandom_range(0, 65535),
                             $urandom_range(0, 255));
    endfunction

    function automatic void queue_reads(int n);
        repeat (n) queue_req(lpr_pkg::REQ_READ_DATA, $urandom_range(0, 65535),
                             $urandom_range(0, 255));
    endfunction

    function automatic void plan_put_packet(int len);
        bit ok;
        ok = (plan_owed == 0 && plan_room >= len + lpr_pkg::HDR_BYTES);
        queue_req(lpr_pkg::REQ_BEGIN_PUT, len, $urandom_range(0, 255));
        if (ok) begin
            queue_data(len);
        end
    endfunction

    function automatic void plan_take_packet();
        queue_req(lpr_pkg::REQ_GET_HDR, $urandom_range(0, 65535), $urandom_range(0, 255));
        queue_reads(plan_left);
    endfunction

    function automatic int draw_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) begin
            return $urandom_range(0, 6);
        end else if (p < 95) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(41, 300);
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        if (err_cnt < 100) begin
            $display("tb: mismatch on result %0d: %s is %0d, expected %0d",
                     taken_cnt, what, got, exp_val);
        end
        err_cnt++;
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            loaded = push;
            if (push && !full) begin
                due_results.push_back(predict_ring(on_wire));
                loaded = 1'b0;
                send_wait = draw_wait(send_calm);
            end
            if (!loaded) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending.size() != 0 &&
                             !(pending[0].hold && due_results.size() != 0)) begin
                    on_wire = pending.pop_front();
                    i_req_type <= on_wire.req;
                    i_pkt_length <= on_wire.len;
                    i_data_byte <= on_wire.data;
                    loaded = 1'b1;
                end
            end
            push <= loaded;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                taken_cnt++;
                if (due_results.size() == 0) begin
                    report_mismatch("transaction with nothing due", 1, 0);
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_got_length !== want.got_length)
                        report_mismatch("got_length", o_got_length, want.got_length);
                    if (o_read_byte !== want.read_byte)
                        report_mismatch("read_byte", o_read_byte, want.read_byte);
                    if (o_last_byte !== want.last_byte)
                        report_mismatch("last_byte", o_last_byte, want.last_byte);
                    if (o_free_space !== want.free_space)
                        report_mismatch("free_space", o_free_space, want.free_space);
                end
                take_wait = draw_wait(take_calm);
            end
            if (take_wait > 0) begin
                take_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int pick;
        int k;
        int j;
        int n;
        int rand_goal;

        // Requests out of order on an empty ring, then small packets.
        queue_req(lpr_pkg::REQ_PUT_DATA, 0, 8'hff);
        queue_req(lpr_pkg::REQ_READ_DATA, 16'hffff, 0);
        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
        queue_req(lpr_pkg::REQ_BEGIN_PUT, 0, 0);
        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
        queue_req(lpr_pkg::REQ_BEGIN_PUT, 16'hffff, 0);
        queue_req(lpr_pkg::REQ_BEGIN_PUT, 3, 0);
        queue_req(lpr_pkg::REQ_BEGIN_PUT, 1, 0);
        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
        queue_req(lpr_pkg::REQ_PUT_DATA, 16'hffff, 8'h00);
        queue_req(lpr_pkg::REQ_PUT_DATA, 0, 8'hff);
        queue_req(lpr_pkg::REQ_PUT_DATA, 0, 8'h5a);
        queue_req(lpr_pkg::REQ_PUT_DATA, 0, 8'ha5);
        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
        queue_reads(3);
        queue_req(lpr_pkg::REQ_READ_DATA, 0, 0);

        hold_next = 1'b1;
        rand_goal = planned + RANDOM_ITEMS;
        while (planned < rand_goal) begin
            pick = $urandom_range(0, 99);
            if (plan_owed != 0 && pick < 90) begin
                queue_data(plan_owed);
            end else if (plan_left != 0 && pick < 90) begin
                queue_reads(plan_left);
            end else if (pick < 45) begin
                plan_put_packet(draw_len());
            end else if (pick < 78) begin
                plan_take_packet();
            end else if (pick < 88) begin
                // A packet broken by a request that does not belong there.
                k = $urandom_range(2, 12);
                if ($urandom_range(0, 1) == 0 && plan_owed == 0 &&
                    plan_room >= k + lpr_pkg::HDR_BYTES) begin
                    queue_req(lpr_pkg::REQ_BEGIN_PUT, k, $urandom_range(0, 255));
                    j = $urandom_range(1, k - 1);
                    queue_data(j);
                    case ($urandom_range(0, 2))
                        0: queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
                        1: queue_req(lpr_pkg::REQ_BEGIN_PUT, $urandom_range(0, 65535), 0);
                        default: queue_req(lpr_pkg::REQ_READ_DATA, 0, 0);
                    endcase
                    queue_data(k - j);
                end else if (plan_owed == 0 && plan_left == 0 &&
                             plan_room != lpr_pkg::BUF_BYTES - 1) begin
                    queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
                    n = plan_left;
                    j = $urandom_range(0, n);
                    queue_reads(j);
                    if ($urandom_range(0, 1) == 0) begin
                        queue_req(lpr_pkg::REQ_GET_HDR, 0, 0);
                    end else begin
                        queue_req(lpr_pkg::REQ_PUT_DATA, 0, $urandom_range(0, 255));
                    end
                    queue_reads(n - j);
                end
            end else begin
                queue_req(lpr_pkg::REQ_W'($urandom_range(0, 3)),
                          ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 15),
                          $urandom_range(0, 255));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || push || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: length_prefixed_packet_ring.f
hdl/lpr_pkg.sv
hdl/lpr_front.sv
hdl/lpr_back.sv
hdl/lpr_resq.sv
hdl/length_prefixed_packet_ring.sv
hdl/lpr_checker.sv
bench/tb.sv
